>>> hdl/ialu_pkg.sv
// shared types, mode codes and controller commands for the iterative integer alu
package ialu_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_WIDTH = $clog2(DATA_WIDTH);

   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_SUB = 3'd1;
   localparam logic [2:0] MODE_MUL = 3'd2;
   localparam logic [2:0] MODE_DIV = 3'd3;
   localparam logic [2:0] MODE_POW = 3'd4;

   typedef struct packed {
      logic [2:0]                   mode;
      logic signed [DATA_WIDTH-1:0] operand_a;
      logic signed [DATA_WIDTH-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result;
      logic                         divide_by_zero;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_MUL_ACC,
      CMD_SQUARE,
      CMD_DIV_STEP,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic [2:0] req_mode;
      logic       req_b_zero;
      logic       req_b_pos;
      logic       expo_zero;
      logic       expo_lsb;
      logic       div_last;
   } status_type;

endpackage

>>> hdl/ialu_dp.sv
// datapath of the iterative integer alu: operand registers, shared multiplier, divide step
module ialu_dp (
   input  logic                clock,
   input  ialu_pkg::req_type   req,
   input  ialu_pkg::cmd_type   cmd,
   output ialu_pkg::status_type status,
   output ialu_pkg::rsp_type   rsp
);

   localparam int W  = ialu_pkg::DATA_WIDTH;
   localparam int CW = ialu_pkg::COUNT_WIDTH;

   logic [W-1:0]  acc_ff, acc_in;
   logic [W-1:0]  sq_ff, sq_in;
   logic [W-1:0]  expo_ff, expo_in;
   logic [CW-1:0] count_ff, count_in;
   logic          div_ff, div_in;
   logic          neg_ff, neg_in;
   logic          dz_ff, dz_in;
   ialu_pkg::rsp_type rsp_ff, rsp_in;

   logic [W-1:0]   a_u, b_u, mag_a, mag_b;
   logic [W-1:0]   mul_x;
   logic [W-1:0]   prod;
   logic [W-1:0]   trial;
   logic           fits;

   assign a_u   = req.operand_a;
   assign b_u   = req.operand_b;
   assign mag_a = a_u[W-1] ? (~a_u + W'(1)) : a_u;
   assign mag_b = b_u[W-1] ? (~b_u + W'(1)) : b_u;

   // one multiplier, shared between acc*sq and sq*sq, low word only
   assign mul_x = (cmd == ialu_pkg::CMD_SQUARE) ? sq_ff : acc_ff;
   assign prod  = mul_x * sq_ff;

   // restoring divide: remainder in sq, dividend/quotient in expo, divisor in acc
   assign trial = {sq_ff[W-2:0], expo_ff[W-1]};
   assign fits  = trial >= acc_ff;

   always_comb begin
      acc_in   = acc_ff;
      sq_in    = sq_ff;
      expo_in  = expo_ff;
      count_in = count_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      dz_in    = dz_ff;
      rsp_in   = rsp_ff;
      case (cmd)
         ialu_pkg::CMD_LOAD: begin
            sq_in    = a_u;
            expo_in  = b_u;
            count_in = '0;
            div_in   = (req.mode == ialu_pkg::MODE_DIV);
            neg_in   = a_u[W-1] ^ b_u[W-1];
            dz_in    = (req.mode == ialu_pkg::MODE_DIV) && (b_u == '0);
            unique case (req.mode)
               ialu_pkg::MODE_ADD: acc_in = a_u + b_u;
               ialu_pkg::MODE_SUB: acc_in = a_u - b_u;
               ialu_pkg::MODE_MUL: acc_in = b_u;
               ialu_pkg::MODE_DIV: begin
                  acc_in  = mag_b;
                  sq_in   = '0;
                  expo_in = mag_a;
               end
               ialu_pkg::MODE_POW: acc_in = W'(1);
               default:            acc_in = '0;
            endcase
         end
         ialu_pkg::CMD_MUL_ACC: acc_in = prod;
         ialu_pkg::CMD_SQUARE: begin
            sq_in   = prod;
            expo_in = {1'b0, expo_ff[W-1:1]};
         end
         ialu_pkg::CMD_DIV_STEP: begin
            sq_in    = fits ? (trial - acc_ff) : trial;
            expo_in  = {expo_ff[W-2:0], fits};
            count_in = count_ff + CW'(1);
         end
         ialu_pkg::CMD_FINISH: begin
            if (dz_ff) begin
               rsp_in.result = '0;
            end else if (div_ff) begin
               rsp_in.result = neg_ff ? (~expo_ff + W'(1)) : expo_ff;
            end else begin
               rsp_in.result = acc_ff;
            end
            rsp_in.divide_by_zero = dz_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      sq_ff    <= sq_in;
      expo_ff  <= expo_in;
      count_ff <= count_in;
      div_ff   <= div_in;
      neg_ff   <= neg_in;
      dz_ff    <= dz_in;
      rsp_ff   <= rsp_in;
   end

   assign status.req_mode   = req.mode;
   assign status.req_b_zero = (b_u == '0);
   assign status.req_b_pos  = !b_u[W-1] && (b_u != '0);
   assign status.expo_zero  = (expo_ff == '0);
   assign status.expo_lsb   = expo_ff[0];
   assign status.div_last   = (count_ff == CW'(W-1));
   assign rsp               = rsp_ff;

endmodule

>>> hdl/ialu_ctrl.sv
// controller state machine of the iterative integer alu
module ialu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  ialu_pkg::status_type status,
   output ialu_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_MUL    = 6'b000010,
      S_POWBIT = 6'b000100,
      S_SQUARE = 6'b001000,
      S_DIV    = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = ialu_pkg::CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd = ialu_pkg::CMD_LOAD;
               if (status.req_mode == ialu_pkg::MODE_MUL) begin
                  state_in = S_MUL;
               end else if (status.req_mode == ialu_pkg::MODE_DIV && !status.req_b_zero) begin
                  state_in = S_DIV;
               end else if (status.req_mode == ialu_pkg::MODE_POW && status.req_b_pos) begin
                  state_in = S_POWBIT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_MUL: begin
            cmd      = ialu_pkg::CMD_MUL_ACC;
            state_in = S_DONE;
         end
         S_POWBIT: begin
            if (status.expo_zero) begin
               state_in = S_DONE;
            end else if (status.expo_lsb) begin
               cmd      = ialu_pkg::CMD_MUL_ACC;
               state_in = S_SQUARE;
            end else begin
               cmd = ialu_pkg::CMD_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd      = ialu_pkg::CMD_SQUARE;
            state_in = S_POWBIT;
         end
         S_DIV: begin
            cmd = ialu_pkg::CMD_DIV_STEP;
            if (status.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd          = ialu_pkg::CMD_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/iterative_integer_alu.sv
// top level of the iterative integer alu: controller, datapath and port checks
// One request transfer carries a mode and two signed 32-bit operands and yields exactly one
// response transfer; all results wrap modulo 2^32. The block works on one request at a time;
// a finished result sits in the response register, so the next request is taken while it
// waits. Add, subtract, the unused modes and divide by zero go straight to the response;
// multiply makes one pass through the 32x32 multiplier, divide runs 32 restoring steps of
// one subtract and compare each, and power takes a square for a zero exponent bit and a
// multiply then a square for a one bit, since multiply and square share one multiplier,
// then ends with the check that finds the exponent used up; an exponent of zero or less
// goes straight to the response. The request side is ready again the cycle after the
// response register is loaded.
module iterative_integer_alu (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ialu_pkg::req_type req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ialu_pkg::rsp_type rsp
);

   // command and status between the two halves
   ialu_pkg::cmd_type    cmd;
   ialu_pkg::status_type status;

   // sequencing: load on request transfer, iterate, then write the response register
   ialu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // operand registers, shared multiplier and divide step, response payload register
   ialu_dp u_dp (
      .clock  (clock),
      .req    (req),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp)
   );

   // the request side is always busy in the cycle after a request transfer
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side not busy after a transfer");

   // a zero-divisor flag always comes with a zero result
   a_dz_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.divide_by_zero |-> rsp.result == '0)
      else $error("divide by zero with nonzero result");

   // the datapath only finishes when the response register is free
   a_finish_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd == ialu_pkg::CMD_FINISH |-> !rsp_valid || !rsp_stall)
      else $error("response register overwritten while stalled");

endmodule

>>> tb/sv/iterative_integer_alu_tb.sv
// self-checking testbench for the iterative integer alu: random and directed requests
module iterative_integer_alu_tb;

   localparam int DATA_WIDTH = ialu_pkg::DATA_WIDTH;

   // spare mode codes: the block answers 0 with no flag
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   localparam logic [DATA_WIDTH-1:0] WORD_ZERO = '0;
   localparam logic [DATA_WIDTH-1:0] WORD_ONE  = 1;
   localparam logic [DATA_WIDTH-1:0] WORD_ALL  = '1;
   localparam logic [DATA_WIDTH-1:0] WORD_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] WORD_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // overall watchdog limit for the whole run, with ample margin over the worst case plus stall tails
   localparam int CYCLE_LIMIT   = 600000;
   localparam int TAIL_CYCLES   = 100;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 338;
   localparam int PRINT_LIMIT   = 40;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ialu_pkg::req_type req       = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ialu_pkg::rsp_type rsp;

   ialu_pkg::req_type pending_q[$];     // requests not yet offered to the block
   ialu_pkg::rsp_type answer_q[$];      // predicted responses, oldest first
   ialu_pkg::rsp_type due_rsp;

   int send_idle_pct  = 0;    // percent of free cycles the sender stays idle
   int recv_stall_pct = 0;    // percent of cycles the receiver stalls
   int hold_trigger   = 0;    // bumped to ask the receiver for a long hold-off
   int hold_seen      = 0;
   int hold_left      = 0;
   int cycle_count    = 0;
   int error_count    = 0;

   iterative_integer_alu uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predicted response for one request
   function automatic ialu_pkg::rsp_type alu_compute(ialu_pkg::req_type r);
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
      logic [DATA_WIDTH-1:0] mag_a;
      logic [DATA_WIDTH-1:0] mag_b;
      logic [DATA_WIDTH-1:0] quo;
      logic [DATA_WIDTH-1:0] acc;
      logic [DATA_WIDTH-1:0] sq;
      logic [DATA_WIDTH-1:0] expo;
      ialu_pkg::rsp_type o;
      a = r.operand_a;
      b = r.operand_b;
      o = '0;
      case (r.mode)
         ialu_pkg::MODE_ADD: begin
            o.result = a + b;
         end
         ialu_pkg::MODE_SUB: begin
            o.result = a - b;
         end
         ialu_pkg::MODE_MUL: begin
            o.result = a * b;
         end
         ialu_pkg::MODE_DIV: begin
            if (b == WORD_ZERO) begin
               o.divide_by_zero = 1'b1;
            end else begin
               // negating the most negative word leaves 2^(n-1) as an unsigned magnitude
               mag_a = a[DATA_WIDTH-1] ? -a : a;
               mag_b = b[DATA_WIDTH-1] ? -b : b;
               quo = mag_a / mag_b;
               if (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) begin
                  quo = -quo;
               end
               o.result = quo;
            end
         end
         ialu_pkg::MODE_POW: begin
            acc = WORD_ONE;
            sq = a;
            expo = b;
            // zero or negative exponent gives one
            if (!expo[DATA_WIDTH-1]) begin
               while (expo != WORD_ZERO) begin
                  if (expo[0]) begin
                     acc = acc * sq;
                  end
                  sq = sq * sq;
                  expo = expo >> 1;
               end
            end
            o.result = acc;
         end
         default: begin
            o.result = WORD_ZERO;
         end
      endcase
      return o;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_operand();
      logic [DATA_WIDTH-1:0] v;
      case ($urandom_range(0, 7)) inside
         0: v = WORD_ZERO;
         1: v = $urandom_range(0, 1) ? WORD_ONE : WORD_ALL;
         2: v = WORD_MAX;
         3: v = WORD_MIN;
         [4:5]: v = $urandom;
         6: v = int'($urandom_range(0, 64)) - 32;
         default: begin
            v = WORD_ONE << $urandom_range(0, DATA_WIDTH - 1);
            if ($urandom_range(0, 1)) begin
               v = ~v;
            end
         end
      endcase
      return v;
   endfunction

   function automatic ialu_pkg::req_type random_request();
      ialu_pkg::req_type r;
      if ($urandom_range(0, 99) < 5) begin
         r.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      end else begin
         r.mode = 3'($urandom_range(ialu_pkg::MODE_ADD, ialu_pkg::MODE_POW));
      end
      r.operand_a = pick_operand();
      r.operand_b = pick_operand();
      // power mostly with short exponents, a few negative, the rest from the general mix
      if (r.mode == ialu_pkg::MODE_POW && $urandom_range(0, 99) < 70) begin
         r.operand_b = int'($urandom_range(0, 44)) - 4;
      end
      return r;
   endfunction

   task automatic queue_request(logic [2:0] m, logic [DATA_WIDTH-1:0] a,
                                logic [DATA_WIDTH-1:0] b);
      ialu_pkg::req_type r;
      r.mode = m;
      r.operand_a = a;
      r.operand_b = b;
      pending_q.push_back(r);
   endtask

   task automatic report_mismatch(string msg);
      // count every mismatch but keep the log short on a badly broken build
      if (error_count < PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
      error_count++;
   endtask

   // sampled at the falling edge so no clocked process is mid-update
   task automatic wait_drained();
      @(negedge clock);
      while (pending_q.size() != 0 || req_valid || answer_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // driver: offers the next pending request only when the slot is free,
   // so a stalled payload never changes and valid stays high until the transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req <= pending_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request that backs the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // monitor: checks each response transfer against the oldest prediction,
   // then records the prediction for a request transfer at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               report_mismatch($sformatf("response %h with no request outstanding",
                                         rsp.result));
            end else begin
               due_rsp = answer_q.pop_front();
               if (rsp.result !== due_rsp.result) begin
                  report_mismatch($sformatf("result %h, predicted %h",
                                            rsp.result, due_rsp.result));
               end
               if (rsp.divide_by_zero !== due_rsp.divide_by_zero) begin
                  report_mismatch($sformatf("divide_by_zero %b, predicted %b",
                                            rsp.divide_by_zero, due_rsp.divide_by_zero));
               end
            end
         end
         if (req_valid && !req_stall) begin
            answer_q.push_back(alu_compute(req));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, every mode and the corner cases
      queue_request(ialu_pkg::MODE_ADD, WORD_MAX, WORD_MAX);
      queue_request(ialu_pkg::MODE_ADD, WORD_MIN, WORD_MIN);
      queue_request(ialu_pkg::MODE_ADD, WORD_ZERO, WORD_ALL);
      queue_request(ialu_pkg::MODE_SUB, WORD_MIN, WORD_ONE);
      queue_request(ialu_pkg::MODE_SUB, WORD_ZERO, WORD_MIN);
      queue_request(ialu_pkg::MODE_MUL, WORD_MAX, WORD_MAX);
      queue_request(ialu_pkg::MODE_MUL, WORD_MIN, WORD_ALL);
      queue_request(ialu_pkg::MODE_MUL, WORD_ALL, WORD_ALL);
      // zero divisor, including a zero dividend
      queue_request(ialu_pkg::MODE_DIV, WORD_MAX, WORD_ZERO);
      queue_request(ialu_pkg::MODE_DIV, WORD_ZERO, WORD_ZERO);
      // most negative over minus one wraps back to most negative
      queue_request(ialu_pkg::MODE_DIV, WORD_MIN, WORD_ALL);
      queue_request(ialu_pkg::MODE_DIV, WORD_MIN, WORD_ONE);
      queue_request(ialu_pkg::MODE_DIV, WORD_MIN, WORD_MIN);
      queue_request(ialu_pkg::MODE_DIV, WORD_MAX, WORD_MIN);
      queue_request(ialu_pkg::MODE_DIV, -7, 2);
      queue_request(ialu_pkg::MODE_DIV, 7, -2);
      queue_request(ialu_pkg::MODE_POW, 3, WORD_ZERO);
      queue_request(ialu_pkg::MODE_POW, 5, WORD_MIN);
      queue_request(ialu_pkg::MODE_POW, 2, DATA_WIDTH - 1);
      queue_request(ialu_pkg::MODE_POW, 2, DATA_WIDTH);
      queue_request(ialu_pkg::MODE_POW, 3, WORD_MAX);
      queue_request(ialu_pkg::MODE_POW, WORD_ALL, WORD_MAX);
      queue_request(ialu_pkg::MODE_POW, WORD_ZERO, WORD_ZERO);
      for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
         queue_request(3'(m), $urandom, $urandom);
      end
      wait_drained();

      // random phases: none, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pending_q.push_back(random_request());
         end
         // long receiver hold-off while the sender keeps offering
         if (phase == 0) begin
            hold_trigger = hold_trigger + 1;
         end
         // wait here until every queued request has gone out and every response has come back
         wait_drained();
      end

      // quiet tail to catch stray responses
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/ialu_pkg.sv
hdl/ialu_dp.sv
hdl/ialu_ctrl.sv
hdl/iterative_integer_alu.sv
tb/sv/iterative_integer_alu_tb.sv
